// ----- rtl/rsct_pkg.sv -----
// ----------------------------------------------------------------------------
// rsct_pkg: shared types and helpers for the ranked score table
// Entry layout, codes, result word and rank/saturation functions.
// ----------------------------------------------------------------------------
package rsct_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 16;
  localparam int SCORE_W     = 32;
  localparam int SUM_W       = 37;
  localparam int TOP_W       = 6;
  localparam int ENTRY_W     = ID_W + SCORE_W;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    logic signed [SUM_W-1:0]   sum;
    logic [1:0]                status;
    logic                      last;
  } res_t;

  // true when (sa, ia) ranks ahead of (sb, ib)
  function automatic logic ranks_before(logic signed [SCORE_W-1:0] sa, logic [ID_W-1:0] ia,
                                        logic signed [SCORE_W-1:0] sb, logic [ID_W-1:0] ib);
    if (sa != sb) begin
      return sa > sb;
    end
    return ia < ib;
  endfunction

  function automatic logic signed [SCORE_W-1:0] sat_add(logic signed [SCORE_W-1:0] a,
                                                        logic signed [SCORE_W-1:0] b);
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end
    return s[SCORE_W-1:0];
  endfunction

endpackage

// ----- rtl/ranked_score_table_unit.sv -----
// ----------------------------------------------------------------------------
// ranked_score_table_unit: top-k leaderboard kept as a sorted table
// Entries live in one RAM in rank order; a sequencer re-ranks and reports.
// ----------------------------------------------------------------------------
// Input words (in_*): tuser holds the kind (add, reset, query), tdata the id,
// the delta and the top count. A word is taken only while the unit is idle.
// Output words (out_*): tdata holds id, score and running sum, tuser the
// status, tlast marks the final word of an input word.
// Add scans the table one entry per cycle to find the id, shifts every entry
// below its old rank up one slot, scans again for the new rank and shifts
// every entry below that rank down one slot, the RAM moving one entry per cycle.
// A query streams one word per cycle while the receiver keeps up; its first
// word passes through the RAM read register and the output register.
// A stalled receiver holds the output register and the query pauses with it;
// the next input word is still taken while a final word waits.
// Reset empties the table at once (only the entry count is cleared); no
// clearing pass runs, so the unit is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module ranked_score_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // item_id[15:0], delta[47:16], top_count[53:48]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // rank_id[15:0], rank_score[47:16], running_sum[84:48]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  logic                                 ram_we, ram_rd_en;
  logic [rsct_pkg::IDX_W-1:0]           ram_wr_addr, ram_rd_addr;
  logic [rsct_pkg::ENTRY_W-1:0]         ram_wr_data, ram_rd_data;
  logic                                 slot_free, res_valid;
  rsct_pkg::res_t                       res;
  rsct_pkg::res_t                       out_r;
  logic                                 out_valid_r;

  assign slot_free = !out_valid_r || out_tready;

  rsct_ram #(
    .WIDTH(rsct_pkg::ENTRY_W),
    .DEPTH(rsct_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  rsct_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_id      (in_tdata[15:0]),
    .in_delta   (in_tdata[47:16]),
    .in_top     (in_tdata[53:48]),
    .ram_we     (ram_we),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.sum, out_r.score, out_r.id};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

endmodule

// ----- rtl/rsct_ram.sv -----
// ----------------------------------------------------------------------------
// rsct_ram: generic simple dual-port RAM
// One write port, one read port with registered data held while rd_en is low.
// ----------------------------------------------------------------------------
module rsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rsct_seq.sv -----
// ----------------------------------------------------------------------------
// rsct_seq: table sequencer
// Scans, shifts and inserts entries in the RAM; emits result words.
// ----------------------------------------------------------------------------
module rsct_seq (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0]                               in_kind,
  input  logic [rsct_pkg::ID_W-1:0]                in_id,
  input  logic signed [rsct_pkg::SCORE_W-1:0]      in_delta,
  input  logic [rsct_pkg::TOP_W-1:0]               in_top,
  output logic                                     ram_we,
  output logic [rsct_pkg::IDX_W-1:0]               ram_wr_addr,
  output logic [rsct_pkg::ENTRY_W-1:0]             ram_wr_data,
  output logic                                     ram_rd_en,
  output logic [rsct_pkg::IDX_W-1:0]               ram_rd_addr,
  input  logic [rsct_pkg::ENTRY_W-1:0]             ram_rd_data,
  input  logic                                     slot_free,
  output logic                                     res_valid,
  output rsct_pkg::res_t                           res
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FIND   = 8'b0000_0010,
    S_REMOVE = 8'b0000_0100,
    S_INSPOS = 8'b0000_1000,
    S_INSERT = 8'b0001_0000,
    S_WRITE  = 8'b0010_0000,
    S_RESP   = 8'b0100_0000,
    S_QUERY  = 8'b1000_0000
  } state_t;

  state_t                               state_r, state_nxt;
  logic [1:0]                           kind_r, kind_nxt;
  logic [rsct_pkg::ID_W-1:0]            id_r, id_nxt;
  logic signed [rsct_pkg::SCORE_W-1:0]  delta_r, delta_nxt;
  logic signed [rsct_pkg::SCORE_W-1:0]  score_r, score_nxt;
  logic [1:0]                           status_r, status_nxt;
  logic [rsct_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [rsct_pkg::IDX_W-1:0]           ipos_r, ipos_nxt;
  logic [rsct_pkg::CNT_W-1:0]           rd_i_r, rd_i_nxt;
  logic [rsct_pkg::CNT_W-1:0]           rem_r, rem_nxt;
  logic                                 pend_r, pend_nxt;
  logic [rsct_pkg::IDX_W-1:0]           lnd_i_r, lnd_i_nxt;
  logic                                 lnd_last_r, lnd_last_nxt;
  logic signed [rsct_pkg::SUM_W-1:0]    sum_r, sum_nxt;

  logic                                 consume, issue, done;
  logic [rsct_pkg::ID_W-1:0]            d_id;
  logic signed [rsct_pkg::SCORE_W-1:0]  d_sc;
  logic signed [rsct_pkg::SUM_W-1:0]    sum_add;
  logic [rsct_pkg::CNT_W-1:0]           qn;

  assign d_id    = ram_rd_data[rsct_pkg::ENTRY_W-1:rsct_pkg::SCORE_W];
  assign d_sc    = ram_rd_data[rsct_pkg::SCORE_W-1:0];
  assign sum_add = sum_r + {{(rsct_pkg::SUM_W-rsct_pkg::SCORE_W){d_sc[rsct_pkg::SCORE_W-1]}}, d_sc};
  assign qn      = (rsct_pkg::CNT_W'(in_top) < cnt_r) ? rsct_pkg::CNT_W'(in_top) : cnt_r;

  assign consume   = pend_r && ((state_r != S_QUERY) || slot_free);
  assign issue     = (rem_r != '0) && (!pend_r || consume);
  assign done      = (rem_r == '0) && !pend_r;
  assign ram_rd_en   = issue;
  assign ram_rd_addr = rd_i_r[rsct_pkg::IDX_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    id_nxt       = id_r;
    delta_nxt    = delta_r;
    score_nxt    = score_r;
    status_nxt   = status_r;
    cnt_nxt      = cnt_r;
    ipos_nxt     = ipos_r;
    rd_i_nxt     = rd_i_r;
    rem_nxt      = rem_r;
    lnd_i_nxt    = lnd_i_r;
    lnd_last_nxt = lnd_last_r;
    sum_nxt      = sum_r;
    pend_nxt     = issue || (pend_r && !consume);
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_wr_addr  = '0;
    ram_wr_data  = ram_rd_data;
    res_valid    = 1'b0;
    res          = '0;

    if (issue) begin
      rd_i_nxt     = (state_r == S_INSERT) ? rd_i_r - 1'b1 : rd_i_r + 1'b1;
      rem_nxt      = rem_r - 1'b1;
      lnd_i_nxt    = rd_i_r[rsct_pkg::IDX_W-1:0];
      lnd_last_nxt = (rem_r == rsct_pkg::CNT_W'(1));
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        pend_nxt = 1'b0;
        if (in_valid) begin
          kind_nxt  = in_kind;
          id_nxt    = in_id;
          delta_nxt = in_delta;
          rd_i_nxt  = '0;
          sum_nxt   = '0;
          case (in_kind)
            rsct_pkg::KIND_ADD, rsct_pkg::KIND_RESET: begin
              rem_nxt   = cnt_r;
              state_nxt = S_FIND;
            end
            rsct_pkg::KIND_QUERY: begin
              rem_nxt = qn;
              if (qn == '0) begin
                id_nxt     = '0;
                score_nxt  = '0;
                status_nxt = rsct_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_QUERY;
              end
            end
            default: begin
              rem_nxt = '0;
            end
          endcase
        end
      end
      S_FIND: begin
        if (pend_r && d_id == id_r) begin
          score_nxt = rsct_pkg::sat_add(d_sc, delta_r);
          rd_i_nxt  = rsct_pkg::CNT_W'(lnd_i_r) + 1'b1;
          rem_nxt   = cnt_r - rsct_pkg::CNT_W'(lnd_i_r) - 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_REMOVE;
        end else if (done) begin
          if (kind_r == rsct_pkg::KIND_RESET) begin
            score_nxt  = '0;
            status_nxt = rsct_pkg::ST_NOTFOUND;
            state_nxt  = S_RESP;
          end else if (cnt_r == rsct_pkg::CNT_W'(rsct_pkg::MAX_ENTRIES)) begin
            score_nxt  = '0;
            status_nxt = rsct_pkg::ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            score_nxt = delta_r;
            rd_i_nxt  = '0;
            rem_nxt   = cnt_r;
            state_nxt = S_INSPOS;
          end
        end
      end
      S_REMOVE: begin
        // shift the entries below the hole up by one rank
        if (pend_r) begin
          ram_we      = 1'b1;
          ram_wr_addr = lnd_i_r - 1'b1;
        end
        if (done) begin
          cnt_nxt = cnt_r - 1'b1;
          rd_i_nxt = '0;
          if (kind_r == rsct_pkg::KIND_RESET) begin
            score_nxt  = '0;
            status_nxt = rsct_pkg::ST_OK;
            state_nxt  = S_RESP;
          end else begin
            rem_nxt   = cnt_r - 1'b1;
            state_nxt = S_INSPOS;
          end
        end
      end
      S_INSPOS: begin
        if (pend_r && rsct_pkg::ranks_before(score_r, id_r, d_sc, d_id)) begin
          ipos_nxt  = lnd_i_r;
          rd_i_nxt  = cnt_r - 1'b1;
          rem_nxt   = cnt_r - rsct_pkg::CNT_W'(lnd_i_r);
          pend_nxt  = 1'b0;
          state_nxt = S_INSERT;
        end else if (done) begin
          ipos_nxt  = cnt_r[rsct_pkg::IDX_W-1:0];
          rem_nxt   = '0;
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        // move entries down one rank from the bottom to open the slot
        if (pend_r) begin
          ram_we      = 1'b1;
          ram_wr_addr = lnd_i_r + 1'b1;
        end
        if (done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we      = 1'b1;
        ram_wr_addr = ipos_r;
        ram_wr_data = {id_r, score_r};
        cnt_nxt     = cnt_r + 1'b1;
        status_nxt  = rsct_pkg::ST_OK;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          res_valid  = 1'b1;
          res.id     = id_r;
          res.score  = score_r;
          res.sum    = '0;
          res.status = status_r;
          res.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_QUERY: begin
        if (consume) begin
          res_valid  = 1'b1;
          res.id     = d_id;
          res.score  = d_sc;
          res.sum    = sum_add;
          res.status = rsct_pkg::ST_OK;
          res.last   = lnd_last_r;
          sum_nxt    = sum_add;
        end
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rem_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    id_r       <= id_nxt;
    delta_r    <= delta_nxt;
    score_r    <= score_nxt;
    status_r   <= status_nxt;
    ipos_r     <= ipos_nxt;
    rd_i_r     <= rd_i_nxt;
    lnd_i_r    <= lnd_i_nxt;
    lnd_last_r <= lnd_last_nxt;
    sum_r      <= sum_nxt;
  end

endmodule
